>>> rtl/dts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Differential torque split package
// Shared constants, register codes and channel widths of the torque split core.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 88;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int WHEEL_W     = 18;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DIFF_MODE   = 2'd0,
    CFG_FRONT_SHARE = 2'd1,
    CFG_GRIP_GAIN   = 2'd2,
    CFG_SLIP_GAIN   = 2'd3
  } cfg_index_t;

  localparam logic [1:0] MODE_OPEN  = 2'd0;
  localparam logic [1:0] MODE_SPOOL = 2'd1;
  localparam logic [1:0] MODE_LSD   = 2'd2;

  localparam logic [1:0]  RST_DIFF_MODE   = MODE_OPEN;
  localparam logic [15:0] RST_FRONT_SHARE = 16'd16384;
  localparam logic [15:0] RST_GRIP_GAIN   = 16'd4096;
  localparam logic [15:0] RST_SLIP_GAIN   = 16'd4096;

  localparam logic [15:0] SHARE_ONE      = 16'd32768;
  localparam logic [15:0] GRIP_FLOOR     = 16'd819;
  localparam logic [15:0] OPEN_GRIP_GAIN = 16'd1434;
  localparam logic [15:0] OPEN_SLIP_GAIN = 16'd901;
  localparam int          OPEN_LIMIT     = 9830;
  localparam int          LSD_LIMIT      = 14746;
  localparam int          PASS_ON        = 22938;
  localparam int          KEEP_OFF       = 6554;

endpackage : dts_pkg
`default_nettype wire

>>> rtl/differential_torque_split_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Differential torque split core
// Splits one drive torque over four wheels by axle share, grip and slip bias,
// with off-ground handling per differential mode, and reports the mean lock.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  cfg_*     in         register index, 16-bit write data
//  in_*      in         drive torque, four grips, four slips, contact mask
//  out_*     out        four wheel torques, lock amount
//
//  One transaction enters per cycle while the output is not stalled; results
//  pass through five register stages: axle split and gain products,
//  bias clamp, wheel split, left off-ground step, right off-ground step.
//  Reset clears the stage valid bits and loads the default configuration.
//  A stall on the output fills empty stages first, so input continues while
//  bubbles remain in the pipeline.
// ----------------------------------------------------------------------------
module differential_torque_split_core
  import dts_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // drive_torque, fl_grip, fr_grip, rl_grip, rr_grip, fl_slip, fr_slip,
  // rl_slip, rr_slip, contact_mask, zero fill
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // fl_torque, fr_torque, rl_torque, rr_torque, lock_amount
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int STAGES = 5;

  logic [1:0]  diff_mode_r;
  logic [15:0] front_share_r;
  logic [15:0] grip_gain_r;
  logic [15:0] slip_gain_r;

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] stage_en;
  logic              pass_on;

  // Stage 1 registers.
  logic signed [16:0] s1_front_r, s1_front_nxt;
  logic signed [15:0] s1_drive_r, s1_drive_nxt;
  logic [3:0]         s1_mask_r, s1_mask_nxt;
  logic signed [33:0] s1_gp_r [2];
  logic signed [33:0] s1_gp_nxt [2];
  logic signed [33:0] s1_sp_r [2];
  logic signed [33:0] s1_sp_nxt [2];

  // Stage 2 registers.
  logic signed [16:0] s2_axle_r [2];
  logic signed [16:0] s2_axle_nxt [2];
  logic signed [15:0] s2_bias_r [2];
  logic signed [15:0] s2_bias_nxt [2];
  logic [3:0]         s2_mask_r;

  // Stage 3 to 5 registers.
  logic signed [WHEEL_W-1:0] s3_l_r [2];
  logic signed [WHEEL_W-1:0] s3_l_nxt [2];
  logic signed [WHEEL_W-1:0] s3_r_r [2];
  logic signed [WHEEL_W-1:0] s3_r_nxt [2];
  logic [15:0]               s3_lock_r, s3_lock_nxt;
  logic [3:0]                s3_mask_r;
  logic signed [WHEEL_W-1:0] s4_l_r [2];
  logic signed [WHEEL_W-1:0] s4_l_nxt [2];
  logic signed [WHEEL_W-1:0] s4_r_r [2];
  logic signed [WHEEL_W-1:0] s4_r_nxt [2];
  logic [15:0]               s4_lock_r;
  logic [3:0]                s4_mask_r;
  logic signed [WHEEL_W-1:0] s5_l_r [2];
  logic signed [WHEEL_W-1:0] s5_l_nxt [2];
  logic signed [WHEEL_W-1:0] s5_r_r [2];
  logic signed [WHEEL_W-1:0] s5_r_nxt [2];
  logic [15:0]               s5_lock_r;

  function automatic logic signed [WHEEL_W-1:0] sat_wheel(input logic signed [WHEEL_W:0] v);
    logic signed [WHEEL_W:0] hi;
    logic signed [WHEEL_W:0] lo;
    hi = (WHEEL_W+1)'((1 <<< (WHEEL_W-1)) - 1);
    lo = -(WHEEL_W+1)'(1 <<< (WHEEL_W-1));
    if (v > hi) begin
      return hi[WHEEL_W-1:0];
    end else if (v < lo) begin
      return lo[WHEEL_W-1:0];
    end
    return v[WHEEL_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign pass_on   = (diff_mode_r == MODE_SPOOL) || (diff_mode_r == MODE_LSD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_mode_r   <= RST_DIFF_MODE;
      front_share_r <= RST_FRONT_SHARE;
      grip_gain_r   <= RST_GRIP_GAIN;
      slip_gain_r   <= RST_SLIP_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DIFF_MODE:   diff_mode_r   <= cfg_data[1:0];
        CFG_FRONT_SHARE: front_share_r <= cfg_data;
        CFG_GRIP_GAIN:   grip_gain_r   <= cfg_data;
        CFG_SLIP_GAIN:   slip_gain_r   <= cfg_data;
      endcase
    end
  end

  always_comb begin
    stage_en[STAGES-1] = !valid_r[STAGES-1] || out_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !valid_r[k] || stage_en[k+1];
    end
  end

  assign in_tready = stage_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_r[0] <= in_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (stage_en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // Stage 1: front axle torque and the grip and slip gain products.
  always_comb begin
    logic [15:0]        share_c;
    logic signed [32:0] front_prod;
    logic [15:0]        ga, sa, gl, gr, egl, egr, sl, sr;
    logic [16:0]        absl, absr;
    logic signed [16:0] gd, sd;
    share_c      = (front_share_r > SHARE_ONE) ? SHARE_ONE : front_share_r;
    s1_drive_nxt = $signed(in_tdata[15:0]);
    front_prod   = s1_drive_nxt * $signed({1'b0, share_c});
    s1_front_nxt = 17'((front_prod + 33'sd16384) >>> 15);
    s1_mask_nxt  = in_tdata[147:144];
    if (diff_mode_r == MODE_LSD) begin
      ga = grip_gain_r;
      sa = slip_gain_r;
    end else begin
      ga = OPEN_GRIP_GAIN;
      sa = OPEN_SLIP_GAIN;
    end
    for (int a = 0; a < 2; a++) begin
      gl   = in_tdata[16 + 32*a +: 16];
      gr   = in_tdata[32 + 32*a +: 16];
      sl   = in_tdata[80 + 32*a +: 16];
      sr   = in_tdata[96 + 32*a +: 16];
      egl  = (!s1_mask_nxt[2*a] || gl < GRIP_FLOOR) ? GRIP_FLOOR : gl;
      egr  = (!s1_mask_nxt[2*a+1] || gr < GRIP_FLOOR) ? GRIP_FLOOR : gr;
      gd   = $signed({1'b0, egl}) - $signed({1'b0, egr});
      absl = sl[15] ? (17'd0 - {sl[15], sl}) : {1'b0, sl};
      absr = sr[15] ? (17'd0 - {sr[15], sr}) : {1'b0, sr};
      sd   = $signed(absl - absr);
      s1_gp_nxt[a] = gd * $signed({1'b0, ga});
      s1_sp_nxt[a] = sd * $signed({1'b0, sa});
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      s1_front_r <= s1_front_nxt;
      s1_drive_r <= s1_drive_nxt;
      s1_mask_r  <= s1_mask_nxt;
      s1_gp_r    <= s1_gp_nxt;
      s1_sp_r    <= s1_sp_nxt;
    end
  end

  // Stage 2: rear axle torque and the clamped bias of each axle.
  always_comb begin
    logic signed [35:0] acc;
    logic signed [24:0] rs;
    logic signed [24:0] lim;
    lim = (diff_mode_r == MODE_LSD) ? 25'(LSD_LIMIT) : 25'(OPEN_LIMIT);
    s2_axle_nxt[0] = s1_front_r;
    s2_axle_nxt[1] = $signed({s1_drive_r[15], s1_drive_r}) - s1_front_r;
    for (int a = 0; a < 2; a++) begin
      acc = $signed({{2{s1_gp_r[a][33]}}, s1_gp_r[a]}) - $signed({s1_sp_r[a], 2'b00});
      rs  = 25'((acc + 36'sd1024) >>> 11);
      if (diff_mode_r != MODE_OPEN && diff_mode_r != MODE_LSD) begin
        s2_bias_nxt[a] = '0;
      end else if (rs > lim) begin
        s2_bias_nxt[a] = lim[15:0];
      end else if (rs < -lim) begin
        s2_bias_nxt[a] = 16'(-lim);
      end else begin
        s2_bias_nxt[a] = rs[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s2_axle_r <= s2_axle_nxt;
      s2_bias_r <= s2_bias_nxt;
      s2_mask_r <= s1_mask_r;
    end
  end

  // Stage 3: left and right wheel split and the lock amount.
  always_comb begin
    logic signed [17:0] facl, facr;
    logic signed [34:0] pl, pr;
    logic [15:0]        absb [2];
    logic [16:0]        lsum;
    for (int a = 0; a < 2; a++) begin
      facl = 18'sd32768 + 18'(s2_bias_r[a]);
      facr = 18'sd32768 - 18'(s2_bias_r[a]);
      pl   = s2_axle_r[a] * facl;
      pr   = s2_axle_r[a] * facr;
      s3_l_nxt[a] = WHEEL_W'((pl + 35'sd32768) >>> 16);
      s3_r_nxt[a] = WHEEL_W'((pr + 35'sd32768) >>> 16);
      absb[a] = s2_bias_r[a][15] ? 16'(-s2_bias_r[a]) : s2_bias_r[a];
    end
    lsum        = {1'b0, absb[0]} + {1'b0, absb[1]} + 17'd1;
    s3_lock_nxt = lsum[16:1];
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      s3_l_r    <= s3_l_nxt;
      s3_r_r    <= s3_r_nxt;
      s3_lock_r <= s3_lock_nxt;
      s3_mask_r <= s2_mask_r;
    end
  end

  // Stage 4: left wheel off the ground.
  always_comb begin
    logic signed [35:0] pp, kp;
    for (int a = 0; a < 2; a++) begin
      pp = s3_l_r[a] * 18'sd22938;
      kp = s3_l_r[a] * 18'sd6554;
      s4_l_nxt[a] = s3_l_r[a];
      s4_r_nxt[a] = s3_r_r[a];
      if (!s3_mask_r[2*a]) begin
        if (pass_on) begin
          s4_r_nxt[a] = s3_r_r[a] + WHEEL_W'((pp + 36'sd16384) >>> 15);
        end
        s4_l_nxt[a] = WHEEL_W'((kp + 36'sd16384) >>> 15);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      s4_l_r    <= s4_l_nxt;
      s4_r_r    <= s4_r_nxt;
      s4_lock_r <= s3_lock_r;
      s4_mask_r <= s3_mask_r;
    end
  end

  // Stage 5: right wheel off the ground and output saturation.
  always_comb begin
    logic signed [35:0]    pp, kp;
    logic signed [WHEEL_W:0] lw, rw;
    for (int a = 0; a < 2; a++) begin
      pp = s4_r_r[a] * 18'sd22938;
      kp = s4_r_r[a] * 18'sd6554;
      lw = (WHEEL_W+1)'(s4_l_r[a]);
      rw = (WHEEL_W+1)'(s4_r_r[a]);
      if (!s4_mask_r[2*a+1]) begin
        if (pass_on) begin
          lw = lw + (WHEEL_W+1)'((pp + 36'sd16384) >>> 15);
        end
        rw = (WHEEL_W+1)'((kp + 36'sd16384) >>> 15);
      end
      s5_l_nxt[a] = sat_wheel(lw);
      s5_r_nxt[a] = sat_wheel(rw);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      s5_l_r    <= s5_l_nxt;
      s5_r_r    <= s5_r_nxt;
      s5_lock_r <= s4_lock_r;
    end
  end

  assign out_tvalid = valid_r[STAGES-1];
  assign out_tdata  = {s5_lock_r, s5_r_r[1], s5_l_r[1], s5_r_r[0], s5_l_r[0]};

endmodule : differential_torque_split_core
`default_nettype wire

>>> rtl/dts_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Differential torque split checker
// Port-level properties of the torque split core, bound to the core module.
// ----------------------------------------------------------------------------
module dts_checker
  import dts_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   cfg_valid,
  input wire logic                   cfg_ready,
  input wire logic [CFG_INDEX_W-1:0] cfg_index,
  input wire logic [CFG_DATA_W-1:0]  cfg_data,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed");

  a_lock_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[87:72] <= 16'(LSD_LIMIT))
    else $error("lock amount above bias limit");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

endmodule : dts_checker

bind differential_torque_split_core dts_checker u_dts_checker (.*);
`default_nettype wire
